FILE: design/bst_pkg.sv
// Shared types, character codes and lookup functions for the byte stream tokenizer.
// No dependencies; imported by every module of the block.
package bst_pkg;

    // Longest reported lexeme length; the 8-bit length field caps it at 255.
    localparam int          MAX_LEN   = 255;
    localparam int          LEN_CAP_I = (MAX_LEN < 255) ? MAX_LEN : 255;
    localparam logic [7:0]  LEN_CAP   = 8'(LEN_CAP_I);

    // Input operation codes
    localparam logic OP_CHAR  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_LA    = "a";
    localparam logic [7:0] CH_LZ    = "z";
    localparam logic [7:0] CH_UA    = "A";
    localparam logic [7:0] CH_UZ    = "Z";
    localparam logic [7:0] CH_SEMI  = ";";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_LPAR  = "(";
    localparam logic [7:0] CH_RPAR  = ")";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_E     = "e";
    localparam logic [7:0] CH_N     = "n";
    localparam logic [7:0] CH_D     = "d";
    localparam logic [7:0] CH_P     = "p";
    localparam logic [7:0] CH_R     = "r";
    localparam logic [7:0] CH_I     = "i";
    localparam logic [7:0] CH_T     = "t";

    typedef enum logic [3:0] {
        K_INT    = 4'd0,
        K_ID     = 4'd1,
        K_END    = 4'd2,
        K_PRINT  = 4'd3,
        K_SEMI   = 4'd4,
        K_PLUS   = 4'd5,
        K_MINUS  = 4'd6,
        K_MULT   = 4'd7,
        K_LPAREN = 4'd8,
        K_RPAREN = 4'd9,
        K_ASSIGN = 4'd10,
        K_ERROR  = 4'd11
    } t_kind;

    typedef enum logic [1:0] {
        RUN_NONE   = 2'd0,
        RUN_DIGIT  = 2'd1,
        RUN_LETTER = 2'd2
    } t_run_class;

    // Keyword match progress: prefix of "end" or "print" seen so far
    typedef enum logic [3:0] {
        KW_EMPTY = 4'd0,
        KW_E     = 4'd1,
        KW_EN    = 4'd2,
        KW_END   = 4'd3,
        KW_P     = 4'd4,
        KW_PR    = 4'd5,
        KW_PRI   = 4'd6,
        KW_PRIN  = 4'd7,
        KW_PRINT = 4'd8,
        KW_NONE  = 4'd15
    } t_kw;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] start;
        logic [7:0]  length;
        logic [7:0]  single_char;
        logic        last;
    } t_token;

    // Up to two tokens produced by one input item
    typedef struct packed {
        t_token     tok0;
        t_token     tok1;
        logic [1:0] count;
    } t_token_pair;

    function automatic t_kw next_progress(input t_kw p, input logic [7:0] ch);
        t_kw r;
        r = KW_NONE;
        unique case (p)
            KW_EMPTY: r = (ch == CH_E) ? KW_E : ((ch == CH_P) ? KW_P : KW_NONE);
            KW_E:     r = (ch == CH_N) ? KW_EN    : KW_NONE;
            KW_EN:    r = (ch == CH_D) ? KW_END   : KW_NONE;
            KW_P:     r = (ch == CH_R) ? KW_PR    : KW_NONE;
            KW_PR:    r = (ch == CH_I) ? KW_PRI   : KW_NONE;
            KW_PRI:   r = (ch == CH_N) ? KW_PRIN  : KW_NONE;
            KW_PRIN:  r = (ch == CH_T) ? KW_PRINT : KW_NONE;
            default:  r = KW_NONE;
        endcase
        return r;
    endfunction

    function automatic t_kind punct_kind(input logic [7:0] ch);
        t_kind k;
        k = K_ERROR;
        unique case (ch)
            CH_SEMI:  k = K_SEMI;
            CH_PLUS:  k = K_PLUS;
            CH_MINUS: k = K_MINUS;
            CH_STAR:  k = K_MULT;
            CH_LPAR:  k = K_LPAREN;
            CH_RPAR:  k = K_RPAREN;
            CH_EQ:    k = K_ASSIGN;
            default:  k = K_ERROR;
        endcase
        return k;
    endfunction

endpackage

FILE: design/byte_stream_tokenizer.sv
// Top level of the byte stream tokenizer: input register, lexer and result register.
// Depends on bst_pkg, bst_lexer and bst_token_out.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------------
//  input   | in        | i_valid / o_stall  | i_op, i_char_byte
//  tokens  | out       | o_valid / i_stall  | o_token_kind, o_token_start, o_token_length,
//          |           |                    | o_single_char, o_last
//
// One character is taken per cycle while the token side does not stall and items yield at
// most one token each; an item that yields two tokens holds the result register until both
// have transferred. The first token of an item passes through the input register and then
// the result register before it is on the output.
// Synchronous active-low reset clears the run state, byte offset and all valid flags.
// A stall on the token side backs up into the input register and then raises o_stall.
module byte_stream_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [7:0]  i_char_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_token_kind,
    output logic [31:0] o_token_start,
    output logic [7:0]  o_token_length,
    output logic [7:0]  o_single_char,
    output logic        o_last
);
    import bst_pkg::*;

    logic        r_in_valid;
    logic        r_op;
    logic [7:0]  r_char;
    logic        load_ready;
    logic        fire;
    t_token_pair pair;
    t_token      token;

    assign fire    = r_in_valid && load_ready;
    assign o_stall = r_in_valid && !load_ready;

    // Input register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    // Capture the input payload on transfer
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_op   <= i_op;
            r_char <= i_char_byte;
        end
    end

    bst_lexer u_lexer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_op        (r_op),
        .i_char_byte (r_char),
        .o_pair      (pair)
    );

    bst_token_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (fire),
        .i_pair       (pair),
        .o_load_ready (load_ready),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_token      (token)
    );

    // Unpack the head token onto the output fields
    assign o_token_kind   = token.kind;
    assign o_token_start  = token.start;
    assign o_token_length = token.length;
    assign o_single_char  = token.single_char;
    assign o_last         = token.last;

endmodule

FILE: design/bst_lexer.sv
// Per-character classification, run tracking and token generation.
// Depends on bst_pkg for token types, codes and keyword/punctuation lookups.
module bst_lexer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic                 i_op,
    input  logic [7:0]           i_char_byte,
    output bst_pkg::t_token_pair o_pair
);
    import bst_pkg::*;

    t_run_class  r_class,  n_class;
    logic [31:0] r_start,  n_start;
    logic [7:0]  r_count,  n_count;
    t_kw         r_kw,     n_kw;
    logic [31:0] r_offset, n_offset;

    logic        is_digit, is_letter, is_space;
    t_run_class  ch_class;
    t_token      run_tok, err_run_tok, char_tok;
    t_kind       run_kind;

    // Classify the incoming byte
    assign is_digit  = (i_char_byte >= CH_0) && (i_char_byte <= CH_9);
    assign is_letter = ((i_char_byte >= CH_LA) && (i_char_byte <= CH_LZ)) ||
                       ((i_char_byte >= CH_UA) && (i_char_byte <= CH_UZ));
    assign is_space  = (i_char_byte == CH_SPACE) ||
                       ((i_char_byte >= CH_TAB) && (i_char_byte <= CH_CR));
    assign ch_class  = is_digit ? RUN_DIGIT : RUN_LETTER;

    // Kind of the pending run when it ends cleanly
    always_comb begin
        if (r_class == RUN_DIGIT) begin
            run_kind = K_INT;
        end else if (r_kw == KW_END) begin
            run_kind = K_END;
        end else if (r_kw == KW_PRINT) begin
            run_kind = K_PRINT;
        end else begin
            run_kind = K_ID;
        end
    end

    // Candidate tokens
    always_comb begin
        run_tok             = '0;
        run_tok.kind        = run_kind;
        run_tok.start       = r_start;
        run_tok.length      = r_count;
        err_run_tok         = run_tok;
        err_run_tok.kind    = K_ERROR;
        char_tok            = '0;
        char_tok.kind       = (is_digit || is_letter) ? K_ERROR : punct_kind(i_char_byte);
        char_tok.start      = r_offset;
        char_tok.length     = 8'd1;
        char_tok.single_char = i_char_byte;
    end

    // Next state and emitted tokens
    always_comb begin
        n_class  = r_class;
        n_start  = r_start;
        n_count  = r_count;
        n_kw     = r_kw;
        n_offset = r_offset;
        o_pair   = '0;
        if (i_fire) begin
            if (i_op == OP_FLUSH) begin
                if (r_class != RUN_NONE) begin
                    o_pair.tok0      = run_tok;
                    o_pair.tok0.last = 1'b1;
                    o_pair.count     = 2'd1;
                    n_class = RUN_NONE;
                    n_start = '0;
                    n_count = '0;
                    n_kw    = KW_EMPTY;
                end
            end else begin
                n_offset = r_offset + 32'd1;
                if (is_space) begin
                    if (r_class != RUN_NONE) begin
                        o_pair.tok0      = run_tok;
                        o_pair.tok0.last = 1'b1;
                        o_pair.count     = 2'd1;
                        n_class = RUN_NONE;
                        n_start = '0;
                        n_count = '0;
                        n_kw    = KW_EMPTY;
                    end
                end else if (is_digit || is_letter) begin
                    if (r_class == ch_class) begin
                        // Extend the run
                        if (r_count < LEN_CAP) begin
                            n_count = r_count + 8'd1;
                        end
                        if (ch_class == RUN_LETTER) begin
                            n_kw = next_progress(r_kw, i_char_byte);
                        end
                    end else if (r_class != RUN_NONE) begin
                        // Mixed digit/letter run: error for both parts
                        o_pair.tok0      = err_run_tok;
                        o_pair.tok1      = char_tok;
                        o_pair.tok1.last = 1'b1;
                        o_pair.count     = 2'd2;
                        n_class = RUN_NONE;
                        n_start = '0;
                        n_count = '0;
                        n_kw    = KW_EMPTY;
                    end else begin
                        // Open a new run
                        n_class = ch_class;
                        n_start = r_offset;
                        n_count = 8'd1;
                        n_kw    = (ch_class == RUN_LETTER) ?
                                  next_progress(KW_EMPTY, i_char_byte) : KW_EMPTY;
                    end
                end else begin
                    // Punctuation or unknown byte
                    if (r_class != RUN_NONE) begin
                        o_pair.tok0      = run_tok;
                        o_pair.tok1      = char_tok;
                        o_pair.tok1.last = 1'b1;
                        o_pair.count     = 2'd2;
                        n_class = RUN_NONE;
                        n_start = '0;
                        n_count = '0;
                        n_kw    = KW_EMPTY;
                    end else begin
                        o_pair.tok0      = char_tok;
                        o_pair.tok0.last = 1'b1;
                        o_pair.count     = 2'd1;
                    end
                end
            end
        end
    end

    // Hold run state and byte offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class  <= RUN_NONE;
            r_start  <= '0;
            r_count  <= '0;
            r_kw     <= KW_EMPTY;
            r_offset <= '0;
        end else begin
            r_class  <= n_class;
            r_start  <= n_start;
            r_count  <= n_count;
            r_kw     <= n_kw;
            r_offset <= n_offset;
        end
    end

endmodule

FILE: design/bst_token_out.sv
// Result register: holds up to two tokens from one item and drains them in order.
// Depends on bst_pkg for the token and token pair types.
module bst_token_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  bst_pkg::t_token_pair i_pair,
    output logic                 o_load_ready,
    input  logic                 i_stall,
    output logic                 o_valid,
    output bst_pkg::t_token      o_token
);
    import bst_pkg::*;

    t_token     r_slot0, r_slot1;
    logic [1:0] r_left;
    logic       out_xfer;

    assign o_valid      = (r_left != 2'd0);
    assign out_xfer     = o_valid && !i_stall;
    assign o_token      = r_slot0;
    // Free when empty, or once the last held token transfers this cycle
    assign o_load_ready = (r_left == 2'd0) || ((r_left == 2'd1) && out_xfer);

    // Track tokens still to deliver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else if (i_load) begin
            r_left <= i_pair.count;
        end else if (out_xfer) begin
            r_left <= r_left - 2'd1;
        end
    end

    // Load a new pair or advance the second token into the head slot
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot0 <= i_pair.tok0;
            r_slot1 <= i_pair.tok1;
        end else if (out_xfer) begin
            r_slot0 <= r_slot1;
        end
    end

endmodule

FILE: design/bst_checker.sv
// Port-level checks on the token output of the byte stream tokenizer.
// Depends on bst_pkg for token kinds and on byte_stream_tokenizer, bound at the end of this file.
module bst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [3:0]  o_token_kind,
    input logic [31:0] o_token_start,
    input logic [7:0]  o_token_length,
    input logic [7:0]  o_single_char,
    input logic        o_last
);
    import bst_pkg::*;

    // Hold a stalled token
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_kind) &&
        $stable(o_token_start) && $stable(o_token_length) && $stable(o_last))
        else $error("stalled token changed");

    // Drop all tokens after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("token valid right after reset");

    // Every token covers at least one character
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_token_length != 8'd0)
        else $error("zero-length token");

    // Punctuation tokens are one character long
    a_punct_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind >= K_SEMI && o_token_kind <= K_ASSIGN |->
        o_token_length == 8'd1 && o_single_char != 8'd0)
        else $error("punctuation token malformed");

    // A carried character only appears on one-character tokens
    a_char_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_single_char != 8'd0 |-> o_token_length == 8'd1)
        else $error("character carried on a run token");

endmodule

bind byte_stream_tokenizer bst_checker u_bst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_token_kind   (o_token_kind),
    .o_token_start  (o_token_start),
    .o_token_length (o_token_length),
    .o_single_char  (o_single_char),
    .o_last         (o_last)
);

FILE: dv/token_checker.sv
// Token checker for the byte stream tokenizer: watches both channels, predicts tokens, compares.
// Depends on bst_pkg for the token struct, kinds, run classes and keyword progress codes.
`timescale 1ns / 1ps

module token_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_op,
    input  logic [7:0]  i_char_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [3:0]  i_kind,
    input  logic [31:0] i_start,
    input  logic [7:0]  i_length,
    input  logic [7:0]  i_single_char,
    input  logic        i_last,
    output int          o_pending,
    output int          o_errors
);
    import bst_pkg::*;

    // Lexer state as the stream should leave it
    t_run_class  run_cls;
    logic [31:0] run_from;
    logic [7:0]  run_len;
    t_kw         kw;
    logic [31:0] next_offset;

    t_token tokens_due[$];
    int     errors = 0;

    function automatic bit is_blank(logic [7:0] ch);
        return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] ch);
        return ch >= CH_0 && ch <= CH_9;
    endfunction

    function automatic bit is_letter(logic [7:0] ch);
        return (ch >= CH_LA && ch <= CH_LZ) || (ch >= CH_UA && ch <= CH_UZ);
    endfunction

    // Follow the run along "end" or "print"; any miss sticks at KW_NONE
    function automatic t_kw kw_step(t_kw p, logic [7:0] ch);
        string end_word;
        string print_word;
        int    idx;
        end_word   = "end";
        print_word = "print";
        idx        = int'(p);
        if (p == KW_EMPTY)
            return (ch == CH_E) ? KW_E : ((ch == CH_P) ? KW_P : KW_NONE);
        if (p >= KW_E && p <= KW_EN && ch == end_word[idx])
            return t_kw'(idx + 1);
        if (p >= KW_P && p <= KW_PRIN && ch == print_word[idx - 3])
            return t_kw'(idx + 1);
        return KW_NONE;
    endfunction

    function automatic t_kind pending_kind();
        if (run_cls == RUN_DIGIT) return K_INT;
        if (kw == KW_END)         return K_END;
        if (kw == KW_PRINT)       return K_PRINT;
        return K_ID;
    endfunction

    function automatic t_kind punct_of(logic [7:0] ch);
        case (ch)
            CH_SEMI:  return K_SEMI;
            CH_PLUS:  return K_PLUS;
            CH_MINUS: return K_MINUS;
            CH_STAR:  return K_MULT;
            CH_LPAR:  return K_LPAREN;
            CH_RPAR:  return K_RPAREN;
            CH_EQ:    return K_ASSIGN;
            default:  return K_ERROR;
        endcase
    endfunction

    function automatic t_token make_token(t_kind k, logic [31:0] s, logic [7:0] len,
                                          logic [7:0] c);
        t_token t;
        t.kind        = k;
        t.start       = s;
        t.length      = len;
        t.single_char = c;
        t.last        = 1'b0;
        return t;
    endfunction

    task automatic drop_run();
        run_cls  = RUN_NONE;
        run_from = '0;
        run_len  = '0;
        kw       = KW_EMPTY;
    endtask

    // Advance the lexer by one accepted transfer and queue the tokens it yields
    task automatic lex_item(logic op, logic [7:0] ch);
        t_token     made[2];
        int         n;
        t_run_class cls;
        n = 0;
        if (op == OP_FLUSH) begin
            if (run_cls != RUN_NONE) begin
                made[n] = make_token(pending_kind(), run_from, run_len, 8'd0);
                n++;
                drop_run();
            end
        end else begin
            if (is_blank(ch)) begin
                if (run_cls != RUN_NONE) begin
                    made[n] = make_token(pending_kind(), run_from, run_len, 8'd0);
                    n++;
                    drop_run();
                end
            end else if (is_digit(ch) || is_letter(ch)) begin
                cls = is_digit(ch) ? RUN_DIGIT : RUN_LETTER;
                if (run_cls == cls) begin
                    if (run_len < LEN_CAP) run_len++;
                    if (cls == RUN_LETTER) kw = kw_step(kw, ch);
                end else if (run_cls != RUN_NONE) begin
                    // class clash: the run and the offending character are both errors
                    made[0] = make_token(K_ERROR, run_from, run_len, 8'd0);
                    made[1] = make_token(K_ERROR, next_offset, 8'd1, ch);
                    n = 2;
                    drop_run();
                end else begin
                    run_cls  = cls;
                    run_from = next_offset;
                    run_len  = 8'd1;
                    kw       = (cls == RUN_LETTER) ? kw_step(KW_EMPTY, ch) : KW_EMPTY;
                end
            end else begin
                if (run_cls != RUN_NONE) begin
                    made[n] = make_token(pending_kind(), run_from, run_len, 8'd0);
                    n++;
                    drop_run();
                end
                made[n] = make_token(punct_of(ch), next_offset, 8'd1, ch);
                n++;
            end
            next_offset++;
        end
        for (int i = 0; i < n; i++) begin
            made[i].last = (i == n - 1);
            tokens_due = {tokens_due, made[i]};
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: token %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Predict on input transfers, compare on token transfers
    always @(posedge i_clk) begin : watch
        t_token want;
        if (!i_rst_n) begin
            drop_run();
            next_offset = '0;
            tokens_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) lex_item(i_op, i_char_byte);
            if (i_out_valid && !i_out_stall) begin
                if (tokens_due.size() == 0) begin
                    $display("%0t: unexpected token, expected none, actual kind %0d start %0d",
                             $time, i_kind, i_start);
                    errors++;
                end else begin
                    want = tokens_due.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_kind));
                    check_field("start", want.start, i_start);
                    check_field("length", 32'(want.length), 32'(i_length));
                    check_field("single_char", 32'(want.single_char), 32'(i_single_char));
                    check_field("last", 32'(want.last), 32'(i_last));
                end
            end
        end
        o_pending <= tokens_due.size();
        o_errors  <= errors;
    end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the byte stream tokenizer: clock, reset, character stimulus and verdict.
// Depends on bst_pkg, byte_stream_tokenizer and token_checker.
`timescale 1ns / 1ps

module tb_top;
    import bst_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        i_op        = OP_CHAR;
    logic [7:0]  i_char_byte = 8'd0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_token_kind;
    logic [31:0] o_token_start;
    logic [7:0]  o_token_length;
    logic [7:0]  o_single_char;
    logic        o_last;

    int tx_idle_pct = 20;
    int rx_idle_pct = 56;
    int items_sent  = 0;
    int tokens_seen = 0;
    int idle_cycles = 0;
    int pending;
    int fail_count;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    byte_stream_tokenizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_char_byte    (i_char_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_single_char  (o_single_char),
        .o_last         (o_last)
    );

    token_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_op          (i_op),
        .i_char_byte   (i_char_byte),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_kind        (o_token_kind),
        .i_start       (o_token_start),
        .i_length      (o_token_length),
        .i_single_char (o_single_char),
        .i_last        (o_last),
        .o_pending     (pending),
        .o_errors      (fail_count)
    );

    // Random backpressure on the token side
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) tokens_seen <= tokens_seen + 1;
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("byte_stream_tokenizer test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one item, with random idle cycles ahead of it, and hold it until transfer
    task automatic send_item(logic op, logic [7:0] ch);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_char_byte <= ch;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic send_word(string w);
        for (int i = 0; i < w.len(); i++) send_item(OP_CHAR, w[i]);
    endtask

    function automatic logic [7:0] any_letter();
        logic [7:0] base;
        base = $urandom_range(1) ? CH_LA : CH_UA;
        return base + 8'($urandom_range(25));
    endfunction

    // Hold the sender off until every predicted token has arrived
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // One random fragment: mostly lexically sensible pieces, some noise
    task automatic send_fragment();
        string      keyword_like[13];
        string      punct_set;
        int         pick;
        int         len;
        logic [7:0] c;
        keyword_like = '{"end", "print", "en", "prin", "ends", "printx", "e", "p",
                         "pr", "endx", "x", "Print", "END"};
        punct_set    = ";+-*()=";
        pick         = $urandom_range(99);
        if (pick < 18) begin
            send_word(keyword_like[$urandom_range(12)]);
        end else if (pick < 36) begin
            len = $urandom_range(7, 1);
            repeat (len) send_item(OP_CHAR, any_letter());
        end else if (pick < 52) begin
            len = $urandom_range(6, 1);
            repeat (len) send_item(OP_CHAR, CH_0 + 8'($urandom_range(9)));
        end else if (pick < 68) begin
            send_item(OP_CHAR, punct_set[$urandom_range(6)]);
        end else if (pick < 82) begin
            len = $urandom_range(5);
            c   = (len == 0) ? CH_SPACE : CH_TAB + 8'(len - 1);
            send_item(OP_CHAR, c);
        end else if (pick < 92) begin
            send_item(OP_CHAR, 8'($urandom_range(255)));
        end else begin
            send_item(OP_FLUSH, 8'($urandom_range(255)));
        end
    endtask

    initial begin : stimulus
        int saturating_len;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: keywords, class clashes both ways, every punctuator, byte extremes, flushes
        send_word("end print;7z Q8(+-*)=");
        send_item(OP_CHAR, 8'h00);
        send_item(OP_CHAR, 8'hFF);
        send_item(OP_CHAR, "k");
        send_item(OP_FLUSH, 8'hA5);
        send_item(OP_FLUSH, 8'h5A);
        drain();

        // Sender idles lightly, receiver heavily
        while (items_sent < 330) send_fragment();
        drain();

        // Swap the idle profile
        tx_idle_pct = 56;
        rx_idle_pct = 20;
        while (items_sent < 640) send_fragment();
        drain();

        // Full rate; one run long enough to saturate the length field
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        saturating_len = 258;
        if ($urandom_range(1)) begin
            send_word("print");
            repeat (saturating_len - 5) send_item(OP_CHAR, any_letter());
        end else begin
            repeat (saturating_len) send_item(OP_CHAR, CH_0 + 8'($urandom_range(9)));
        end
        send_item(OP_FLUSH, 8'h00);
        while (items_sent < 960) send_fragment();
        send_item(OP_FLUSH, 8'hFF);

        drain();
        repeat (8) @(posedge i_clk);

        $display("run: %0d input transfers, %0d token transfers checked", items_sent, tokens_seen);
        $display("run: keywords, clashes, punctuation, noise bytes, flushes, one saturated run");
        if (fail_count == 0) begin
            $display("byte_stream_tokenizer test passed");
        end else begin
            $display("byte_stream_tokenizer test failed");
        end
        $finish;
    end

endmodule
